FILE: rtl/lsmaw_pkg.sv
// Shared widths, state encoding and operand selectors for the crossover filter.
`timescale 1ns / 1ps
package lsmaw_pkg;

    // Field widths
    localparam int PRICE_W  = 32;
    localparam int OUT_W    = 40;
    localparam int WL_W     = 9;
    localparam int SL_W     = 7;

    // Datapath widths, sized for the largest supported window lengths
    localparam int SUM_W    = 45;
    localparam int WSUM_W   = 56;
    localparam int SX_W     = 24;
    localparam int SXX_W    = 36;
    localparam int MAG_W    = 80;
    localparam int ACC_W    = 61;
    localparam int DSUM_W   = 20;

    // Shift-add multiplier
    localparam int MUL_A_W   = 36;
    localparam int MUL_B_W   = 56;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    // Restoring divider
    localparam int DIV_N_W   = 81;
    localparam int DIV_D_W   = 48;
    localparam int DIV_CNT_W = 7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_EVAL,
        ST_MUL,
        ST_MULW,
        ST_CALC,
        ST_DIV,
        ST_DIVW,
        ST_LSTORE,
        ST_SMOOTH,
        ST_SPREP,
        ST_SDIV,
        ST_SDIVW,
        ST_FLAGS,
        ST_OUT
    } state_t;

    // Products formed on the shared multiplier, in order
    typedef enum logic [1:0] {
        MUL_SXX_SUM,
        MUL_SX_WSUM,
        MUL_N_SXX,
        MUL_SX_SX
    } mul_op_t;

    typedef struct packed {
        logic start;
        logic done;
    } unit_hs_t;

endpackage

FILE: rtl/lsmaw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lsmaw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lsmaw_mul.sv
// Shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module lsmaw_mul (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [lsmaw_pkg::MUL_A_W-1:0]   op_a,
    input  logic [lsmaw_pkg::MUL_B_W-1:0]   op_b,
    output logic                            done,
    output logic [lsmaw_pkg::MUL_P_W-1:0]   prod
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [lsmaw_pkg::MUL_CNT_W-1:0]     cnt_reg;
    logic [lsmaw_pkg::MUL_A_W-1:0]       a_reg;
    logic [lsmaw_pkg::MUL_P_W-1:0]       b_reg;
    logic [lsmaw_pkg::MUL_P_W-1:0]       acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lsmaw_pkg::MUL_CNT_W'(lsmaw_pkg::MUL_A_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lsmaw_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= lsmaw_pkg::MUL_P_W'(op_b);
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (a_reg[0]) begin
                acc_reg <= acc_reg + b_reg;
            end
            a_reg <= a_reg >> 1;
            b_reg <= b_reg << 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: rtl/lsmaw_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lsmaw_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [lsmaw_pkg::DIV_N_W-1:0]   num,
    input  logic [lsmaw_pkg::DIV_D_W-1:0]   den,
    output logic                            done,
    output logic [lsmaw_pkg::DIV_N_W-1:0]   quo
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [lsmaw_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [lsmaw_pkg::DIV_N_W-1:0]       quo_reg;
    logic [lsmaw_pkg::DIV_D_W-1:0]       rem_reg;
    logic [lsmaw_pkg::DIV_D_W-1:0]       den_reg;
    logic [lsmaw_pkg::DIV_D_W:0]         shifted;
    logic [lsmaw_pkg::DIV_D_W:0]         diff;
    logic                                take;

    assign shifted = {rem_reg, quo_reg[lsmaw_pkg::DIV_N_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign take    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lsmaw_pkg::DIV_CNT_W'(lsmaw_pkg::DIV_N_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lsmaw_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // numerator bits shift out of the top as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[lsmaw_pkg::DIV_D_W-1:0] : shifted[lsmaw_pkg::DIV_D_W-1:0];
            quo_reg <= {quo_reg[lsmaw_pkg::DIV_N_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/lsma_wma_crossover_filter_core.sv
// Least-squares moving average with weighted smoothing and crossover flags.
// Items are processed one at a time: s_tready is high only in the idle state, so no new close
// price is taken until the previous result is loaded into the output register. The line is not
// computed while the window is not full, the regression multiply/divide is skipped for n = 1
// (n = window length), and smoothing is skipped while too few line values are held (p = smooth
// length); the shift-add multiplier (four products) and the restoring divider are shared.
// Reset (aresetn low, synchronous): window_length 225, smooth_length 8, all counters cleared.
`timescale 1ns / 1ps
module lsma_wma_crossover_filter_core #(
    parameter int MAX_WINDOW = 256,
    parameter int MAX_SMOOTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // close_price[31:0]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // line_value[39:0], line_valid[40], smoothed_value[80:41], smoothed_valid[81],
    // cross_up[82], cross_down[83], line_above[84], zero pad[87:85]
    output logic [87:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int LAW = $clog2(MAX_SMOOTH);
    localparam int LCW = $clog2(MAX_SMOOTH + 1);
    localparam int OW  = lsmaw_pkg::OUT_W;

    localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    lsmaw_pkg::state_t  state_reg, state_next;
    lsmaw_pkg::mul_op_t mul_sel_reg;

    // configuration
    logic [lsmaw_pkg::WL_W-1:0] wl_reg;
    logic [lsmaw_pkg::SL_W-1:0] sl_reg;
    logic                       cfg_wr;

    // per-item control
    logic [CW-1:0]  n_cfg, n_reg, k_reg, kd_reg, seen_reg;
    logic [LCW-1:0] p_cfg, p_reg, lk_reg, lkd_reg, lcount_reg, lcount_inc;
    logic           iss_reg, liss_reg;
    logic [AW-1:0]  ptr_reg, ptr_inc;
    logic [LAW-1:0] lptr_reg, lptr_inc;
    logic           accept;

    // accumulators
    logic [lsmaw_pkg::PRICE_W-1:0] price_reg;
    logic [lsmaw_pkg::SUM_W-1:0]   sum_reg;
    logic [lsmaw_pkg::WSUM_W-1:0]  wsum_reg;
    logic [lsmaw_pkg::SX_W-1:0]    sx_reg;
    logic [lsmaw_pkg::SXX_W-1:0]   sxx_reg;
    logic signed [lsmaw_pkg::ACC_W-1:0] acc_reg;
    logic [lsmaw_pkg::DSUM_W-1:0]  dsum_reg;
    logic [CW+31:0]                kp;
    logic [2*CW-1:0]               kk;
    logic [LCW-1:0]                wgt;
    logic signed [LCW+OW:0]        sprod;
    logic [lsmaw_pkg::ACC_W-1:0]   acc_abs;

    // regression terms
    logic [lsmaw_pkg::MAG_W-1:0]   prod_a_reg, prod_b_reg, t1_reg, mag_reg;
    logic [lsmaw_pkg::DIV_D_W-1:0] c_reg;
    logic                          neg_reg;

    // results
    logic signed [OW-1:0] line_reg, smooth_reg, prev_line_reg, prev_smooth_reg, sat_val;
    logic                 lv_reg, sv_reg, prev_both_reg;
    logic                 up_reg, down_reg, above_reg;
    logic [87:0]          m_tdata_reg;
    logic                 m_tvalid_reg;

    // RAM ports
    logic [AW:0]    p_addr_ext;
    logic [AW-1:0]  p_raddr;
    logic [lsmaw_pkg::PRICE_W-1:0] p_rdata;
    logic           p_we;
    logic [LAW:0]   l_addr_ext;
    logic [LAW-1:0] l_raddr;
    logic [OW-1:0]  l_rdata;
    logic           l_we;

    // shared units
    logic                          mul_start, mul_done, div_start, div_done;
    logic [lsmaw_pkg::MUL_A_W-1:0] mul_a;
    logic [lsmaw_pkg::MUL_B_W-1:0] mul_b;
    logic [lsmaw_pkg::MUL_P_W-1:0] mul_p;
    logic [lsmaw_pkg::DIV_N_W-1:0] div_num, div_q;
    logic [lsmaw_pkg::DIV_D_W-1:0] div_den;
    logic [lsmaw_pkg::DIV_N_W-1:0] div_add;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? 32'(sl_reg) : 32'(wl_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= lsmaw_pkg::WL_W'(225);
            sl_reg <= lsmaw_pkg::SL_W'(8);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                sl_reg <= pwdata[lsmaw_pkg::SL_W-1:0];
            end else begin
                wl_reg <= pwdata[lsmaw_pkg::WL_W-1:0];
            end
        end
    end

    always_comb begin
        if (wl_reg == '0) begin
            n_cfg = CW'(1);
        end else if (32'(wl_reg) > 32'(MAX_WINDOW)) begin
            n_cfg = CW'(MAX_WINDOW);
        end else begin
            n_cfg = CW'(wl_reg);
        end
        if (sl_reg == '0) begin
            p_cfg = LCW'(1);
        end else if (32'(sl_reg) > 32'(MAX_SMOOTH)) begin
            p_cfg = LCW'(MAX_SMOOTH);
        end else begin
            p_cfg = LCW'(sl_reg);
        end
    end

    // ---------------- addressing ----------------
    assign accept   = s_tvalid && s_tready;
    assign ptr_inc  = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + 1'b1;
    assign lptr_inc = (lptr_reg == LAW'(MAX_SMOOTH - 1)) ? '0 : lptr_reg + 1'b1;
    assign lcount_inc = (lcount_reg < LCW'(MAX_SMOOTH)) ? lcount_reg + 1'b1 : lcount_reg;

    // circular buffers read back from the newest entry
    always_comb begin
        if ({1'b0, ptr_reg} >= (AW+1)'(k_reg)) begin
            p_addr_ext = {1'b0, ptr_reg} - (AW+1)'(k_reg);
        end else begin
            p_addr_ext = {1'b0, ptr_reg} + (AW+1)'(MAX_WINDOW) - (AW+1)'(k_reg);
        end
        if ({1'b0, lptr_reg} >= (LAW+1)'(lk_reg)) begin
            l_addr_ext = {1'b0, lptr_reg} - (LAW+1)'(lk_reg);
        end else begin
            l_addr_ext = {1'b0, lptr_reg} + (LAW+1)'(MAX_SMOOTH) - (LAW+1)'(lk_reg);
        end
    end

    lsmaw_ram #(
        .WIDTH (lsmaw_pkg::PRICE_W),
        .DEPTH (MAX_WINDOW)
    ) u_price_ram (
        .clk   (aclk),
        .we    (p_we),
        .waddr (ptr_inc),
        .wdata (s_tdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    lsmaw_ram #(
        .WIDTH (OW),
        .DEPTH (MAX_SMOOTH)
    ) u_line_ram (
        .clk   (aclk),
        .we    (l_we),
        .waddr (lptr_inc),
        .wdata (line_reg),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // ---------------- shared arithmetic ----------------
    always_comb begin
        case (mul_sel_reg)
            lsmaw_pkg::MUL_SXX_SUM: begin
                mul_a = sxx_reg;
                mul_b = lsmaw_pkg::MUL_B_W'(sum_reg);
            end
            lsmaw_pkg::MUL_SX_WSUM: begin
                mul_a = lsmaw_pkg::MUL_A_W'(sx_reg);
                mul_b = wsum_reg;
            end
            lsmaw_pkg::MUL_N_SXX: begin
                mul_a = sxx_reg;
                mul_b = lsmaw_pkg::MUL_B_W'(n_reg);
            end
            lsmaw_pkg::MUL_SX_SX: begin
                mul_a = lsmaw_pkg::MUL_A_W'(sx_reg);
                mul_b = lsmaw_pkg::MUL_B_W'(sx_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lsmaw_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_p)
    );

    // round to nearest: (2*mag + d) / (2*d)
    always_comb begin
        if (state_reg == lsmaw_pkg::ST_SDIV) begin
            div_add = lsmaw_pkg::DIV_N_W'(dsum_reg);
            div_den = lsmaw_pkg::DIV_D_W'({dsum_reg, 1'b0});
        end else begin
            div_add = lsmaw_pkg::DIV_N_W'(c_reg);
            div_den = {c_reg[lsmaw_pkg::DIV_D_W-2:0], 1'b0};
        end
        div_num = lsmaw_pkg::DIV_N_W'({mag_reg, 1'b0}) + div_add;
    end

    lsmaw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    always_comb begin
        if (neg_reg) begin
            sat_val = (div_q > lsmaw_pkg::DIV_N_W'(OUT_MIN)) ? OUT_MIN : -div_q[OW-1:0];
        end else begin
            sat_val = (div_q > lsmaw_pkg::DIV_N_W'(OUT_MAX)) ? OUT_MAX : div_q[OW-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lsmaw_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = lsmaw_pkg::ST_SUM;
            end
            lsmaw_pkg::ST_SUM: begin
                if (k_reg >= n_reg && !iss_reg) state_next = lsmaw_pkg::ST_EVAL;
            end
            lsmaw_pkg::ST_EVAL: begin
                if (seen_reg < n_reg) begin
                    state_next = lsmaw_pkg::ST_FLAGS;
                end else if (n_reg == CW'(1)) begin
                    state_next = lsmaw_pkg::ST_LSTORE;
                end else begin
                    state_next = lsmaw_pkg::ST_MUL;
                end
            end
            lsmaw_pkg::ST_MUL: state_next = lsmaw_pkg::ST_MULW;
            lsmaw_pkg::ST_MULW: begin
                if (mul_done) begin
                    state_next = (mul_sel_reg == lsmaw_pkg::MUL_SX_SX) ?
                                 lsmaw_pkg::ST_CALC : lsmaw_pkg::ST_MUL;
                end
            end
            lsmaw_pkg::ST_CALC: state_next = lsmaw_pkg::ST_DIV;
            lsmaw_pkg::ST_DIV:  state_next = lsmaw_pkg::ST_DIVW;
            lsmaw_pkg::ST_DIVW: begin
                if (div_done) state_next = lsmaw_pkg::ST_LSTORE;
            end
            lsmaw_pkg::ST_LSTORE: begin
                state_next = (lcount_inc >= p_reg) ? lsmaw_pkg::ST_SMOOTH : lsmaw_pkg::ST_FLAGS;
            end
            lsmaw_pkg::ST_SMOOTH: begin
                if (lk_reg >= p_reg && !liss_reg) state_next = lsmaw_pkg::ST_SPREP;
            end
            lsmaw_pkg::ST_SPREP: state_next = lsmaw_pkg::ST_SDIV;
            lsmaw_pkg::ST_SDIV:  state_next = lsmaw_pkg::ST_SDIVW;
            lsmaw_pkg::ST_SDIVW: begin
                if (div_done) state_next = lsmaw_pkg::ST_FLAGS;
            end
            lsmaw_pkg::ST_FLAGS: state_next = lsmaw_pkg::ST_OUT;
            lsmaw_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = lsmaw_pkg::ST_IDLE;
            end
            default: state_next = lsmaw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == lsmaw_pkg::ST_IDLE);
        p_we      = (state_reg == lsmaw_pkg::ST_IDLE) && s_tvalid;
        p_raddr   = p_addr_ext[AW-1:0];
        l_we      = (state_reg == lsmaw_pkg::ST_LSTORE);
        l_raddr   = l_addr_ext[LAW-1:0];
        mul_start = (state_reg == lsmaw_pkg::ST_MUL);
        div_start = (state_reg == lsmaw_pkg::ST_DIV) || (state_reg == lsmaw_pkg::ST_SDIV);
    end

    // ---------------- loop terms ----------------
    assign kp      = kd_reg * p_rdata;
    assign kk      = kd_reg * kd_reg;
    assign wgt     = p_reg - lkd_reg;
    assign sprod   = $signed({1'b0, wgt}) * $signed(l_rdata);
    assign acc_abs = acc_reg[lsmaw_pkg::ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lsmaw_pkg::ST_IDLE;
            mul_sel_reg     <= lsmaw_pkg::MUL_SXX_SUM;
            ptr_reg         <= '0;
            lptr_reg        <= '0;
            seen_reg        <= '0;
            lcount_reg      <= '0;
            k_reg           <= '0;
            lk_reg          <= '0;
            iss_reg         <= 1'b0;
            liss_reg        <= 1'b0;
            lv_reg          <= 1'b0;
            sv_reg          <= 1'b0;
            prev_line_reg   <= '0;
            prev_smooth_reg <= '0;
            prev_both_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == lsmaw_pkg::ST_OUT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                lsmaw_pkg::ST_IDLE: begin
                    if (accept) begin
                        ptr_reg <= ptr_inc;
                        if (seen_reg < CW'(MAX_WINDOW)) seen_reg <= seen_reg + 1'b1;
                        k_reg   <= '0;
                        iss_reg <= 1'b0;
                        lv_reg  <= 1'b0;
                        sv_reg  <= 1'b0;
                        mul_sel_reg <= lsmaw_pkg::MUL_SXX_SUM;
                    end
                end
                lsmaw_pkg::ST_SUM: begin
                    iss_reg <= (k_reg < n_reg);
                    if (k_reg < n_reg) k_reg <= k_reg + 1'b1;
                end
                lsmaw_pkg::ST_EVAL: begin
                    lv_reg <= (seen_reg >= n_reg);
                    if (seen_reg < n_reg) lcount_reg <= '0;
                end
                lsmaw_pkg::ST_MULW: begin
                    if (mul_done) begin
                        case (mul_sel_reg)
                            lsmaw_pkg::MUL_SXX_SUM: mul_sel_reg <= lsmaw_pkg::MUL_SX_WSUM;
                            lsmaw_pkg::MUL_SX_WSUM: mul_sel_reg <= lsmaw_pkg::MUL_N_SXX;
                            lsmaw_pkg::MUL_N_SXX:   mul_sel_reg <= lsmaw_pkg::MUL_SX_SX;
                            default:                mul_sel_reg <= lsmaw_pkg::MUL_SXX_SUM;
                        endcase
                    end
                end
                lsmaw_pkg::ST_LSTORE: begin
                    lptr_reg   <= lptr_inc;
                    lcount_reg <= lcount_inc;
                    lk_reg     <= '0;
                    liss_reg   <= 1'b0;
                end
                lsmaw_pkg::ST_SMOOTH: begin
                    liss_reg <= (lk_reg < p_reg);
                    if (lk_reg < p_reg) lk_reg <= lk_reg + 1'b1;
                end
                lsmaw_pkg::ST_SDIVW: begin
                    if (div_done) sv_reg <= 1'b1;
                end
                lsmaw_pkg::ST_FLAGS: begin
                    prev_line_reg   <= line_reg;
                    prev_smooth_reg <= smooth_reg;
                    prev_both_reg   <= lv_reg && sv_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            lsmaw_pkg::ST_IDLE: begin
                price_reg  <= s_tdata;
                n_reg      <= n_cfg;
                p_reg      <= p_cfg;
                sum_reg    <= '0;
                wsum_reg   <= '0;
                sx_reg     <= '0;
                sxx_reg    <= '0;
                line_reg   <= '0;
                smooth_reg <= '0;
            end
            lsmaw_pkg::ST_SUM: begin
                kd_reg <= k_reg;
                if (iss_reg) begin
                    sum_reg  <= sum_reg + lsmaw_pkg::SUM_W'(p_rdata);
                    wsum_reg <= wsum_reg + lsmaw_pkg::WSUM_W'(kp);
                    sx_reg   <= sx_reg + lsmaw_pkg::SX_W'(kd_reg);
                    sxx_reg  <= sxx_reg + lsmaw_pkg::SXX_W'(kk);
                end
            end
            lsmaw_pkg::ST_EVAL: begin
                // single-sample window: the line is the newest price
                if (n_reg == CW'(1)) line_reg <= OW'(price_reg);
            end
            lsmaw_pkg::ST_MULW: begin
                if (mul_done) begin
                    case (mul_sel_reg)
                        lsmaw_pkg::MUL_SXX_SUM: prod_a_reg <= mul_p[lsmaw_pkg::MAG_W-1:0];
                        lsmaw_pkg::MUL_SX_WSUM: prod_b_reg <= mul_p[lsmaw_pkg::MAG_W-1:0];
                        lsmaw_pkg::MUL_N_SXX:   t1_reg     <= mul_p[lsmaw_pkg::MAG_W-1:0];
                        default: c_reg <= t1_reg[lsmaw_pkg::DIV_D_W-1:0]
                                        - mul_p[lsmaw_pkg::DIV_D_W-1:0];
                    endcase
                end
            end
            lsmaw_pkg::ST_CALC: begin
                neg_reg <= prod_a_reg < prod_b_reg;
                mag_reg <= (prod_a_reg < prod_b_reg) ? prod_b_reg - prod_a_reg
                                                     : prod_a_reg - prod_b_reg;
            end
            lsmaw_pkg::ST_DIVW: begin
                if (div_done) line_reg <= sat_val;
            end
            lsmaw_pkg::ST_LSTORE: begin
                acc_reg  <= '0;
                dsum_reg <= '0;
            end
            lsmaw_pkg::ST_SMOOTH: begin
                lkd_reg <= lk_reg;
                if (liss_reg) begin
                    acc_reg  <= acc_reg + lsmaw_pkg::ACC_W'(sprod);
                    dsum_reg <= dsum_reg + lsmaw_pkg::DSUM_W'(wgt);
                end
            end
            lsmaw_pkg::ST_SPREP: begin
                neg_reg <= acc_reg[lsmaw_pkg::ACC_W-1];
                mag_reg <= lsmaw_pkg::MAG_W'(acc_abs);
            end
            lsmaw_pkg::ST_SDIVW: begin
                if (div_done) smooth_reg <= sat_val;
            end
            lsmaw_pkg::ST_FLAGS: begin
                above_reg <= lv_reg && sv_reg && (line_reg > smooth_reg);
                up_reg    <= lv_reg && sv_reg && prev_both_reg
                             && (prev_line_reg <= prev_smooth_reg) && (line_reg > smooth_reg);
                down_reg  <= lv_reg && sv_reg && prev_both_reg
                             && (prev_line_reg >= prev_smooth_reg) && (line_reg < smooth_reg);
            end
            lsmaw_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_reg <= {3'b000, above_reg, down_reg, up_reg, sv_reg,
                                    smooth_reg, lv_reg, line_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule
